// ===== hdl/spectrum_bar_level_tracker_macros.svh =====
`ifndef SPECTRUM_BAR_LEVEL_TRACKER_MACROS_SVH
`define SPECTRUM_BAR_LEVEL_TRACKER_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define SBLT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sblt check failed");

// next-cycle implication
`define SBLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sblt check failed");

`endif

// ===== hdl/sblt_pkg.sv =====
`timescale 1ns / 1ps
package sblt_pkg;

  // fixed-point constants
  localparam logic [16:0] FULL_Q16   = 17'd65536;
  localparam logic [16:0] HALF_Q16   = 17'd32768;
  localparam logic [16:0] SHOWN_MIN  = 17'd3276;
  localparam logic [31:0] LOG_TO_DB  = 32'd394566;
  localparam logic [23:0] DB_RND     = 24'h800000;
  localparam logic [16:0] DB_OFFSET  = 17'd5120;
  localparam logic [16:0] LEVEL_MAX  = 17'd40960;
  localparam logic [31:0] DIV5_RECIP = 32'd209716;
  localparam logic [31:0] FLOOR_RISE = 32'd98;
  localparam logic [27:0] BLEND_BIAS = 28'd10;
  localparam logic [4:0]  LOG_TOP_E  = 5'd27;

  // register reset values
  localparam logic [16:0] ATTACK_RST = 17'd29491;
  localparam logic [16:0] DECAY_RST  = 17'd5243;
  localparam logic [14:0] RANGE_RST  = 15'd7168;
  localparam logic [12:0] TILT_RST   = 13'd2048;
  localparam logic [12:0] MARGIN_RST = 13'd1024;
  localparam logic [15:0] DROP_RST   = 16'd1311;
  localparam logic [6:0]  HOLD_RST   = 7'd18;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK = 3'd0,
    REG_DECAY  = 3'd1,
    REG_RANGE  = 3'd2,
    REG_TILT   = 3'd3,
    REG_MARGIN = 3'd4,
    REG_DROP   = 3'd5,
    REG_HOLD   = 3'd6
  } cfg_reg_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_MEAN_START,
    OP_BLEND,
    OP_NORM,
    OP_SQ_MUL,
    OP_SQ_ADJ,
    OP_DB_MUL,
    OP_DB,
    OP_TILT_MUL,
    OP_TILT_START,
    OP_LEVEL,
    OP_FLOOR_MUL,
    OP_FLOOR,
    OP_REL,
    OP_TGT,
    OP_BAR_MUL,
    OP_BAR,
    OP_ROWS,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_NORM,
    ST_SQ_MUL,
    ST_SQ_ADJ,
    ST_DB_MUL,
    ST_DB,
    ST_TILT_MUL,
    ST_TILT,
    ST_TILT_WAIT,
    ST_FLOOR_MUL,
    ST_FLOOR,
    ST_REL,
    ST_TGT_WAIT,
    ST_BAR_MUL,
    ST_BAR,
    ST_ROWS,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic col_ok;
    logic div_busy;
    logic norm_done;
    logic sq_last;
  } dp_status_t;

  typedef struct packed {
    logic [4:0]  out_column;
    logic [16:0] bar_level;
    logic [3:0]  bar_rows;
    logic [16:0] peak_level;
    logic [2:0]  peak_row;
    logic        peak_shown;
    logic [15:0] level_db;
    logic [15:0] floor_db;
  } out_word_t;

endpackage

// ===== hdl/sblt_in_if.sv =====
`timescale 1ns / 1ps
interface sblt_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] magnitude;
  logic [4:0]  column;
  logic        last_of_column;
  logic        relearn;

  modport source (output valid, magnitude, column, last_of_column, relearn, input ready);
  modport sink (input valid, magnitude, column, last_of_column, relearn, output ready);
endinterface

// ===== hdl/sblt_out_if.sv =====
`timescale 1ns / 1ps
interface sblt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  out_column;
  logic [16:0] bar_level;
  logic [3:0]  bar_rows;
  logic [16:0] peak_level;
  logic [2:0]  peak_row;
  logic        peak_shown;
  logic [15:0] level_db;
  logic [15:0] floor_db;

  modport source (output valid, out_column, bar_level, bar_rows, peak_level, peak_row,
                  peak_shown, level_db, floor_db, input ready);
  modport sink (input valid, out_column, bar_level, bar_rows, peak_level, peak_row,
                peak_shown, level_db, floor_db, output ready);
endinterface

// ===== hdl/sblt_cfg_if.sv =====
`timescale 1ns / 1ps
interface sblt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/sblt_div.sv =====
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module sblt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quotient_o
);

  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [31:0] quo_q, quo_d;
  logic [16:0] shifted;

  // one shift-subtract step
  always_comb begin
    shifted = {rem_q, quo_q[31]};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = 16'(shifted - {1'b0, dvs_q});
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted[15:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/sblt_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer: walks one closed band through the datapath steps
module sblt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sblt_pkg::dp_status_t status_i,
  output sblt_pkg::dp_cmd_t   cmd_o
);

  sblt_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept, can_emit;

  assign accept   = in_valid_i && (state_q == sblt_pkg::ST_IDLE);
  assign can_emit = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sblt_pkg::ST_IDLE: begin
        if (accept && status_i.col_ok && in_last_i) state_d = sblt_pkg::ST_MEAN;
      end
      sblt_pkg::ST_MEAN:      state_d = sblt_pkg::ST_MEAN_WAIT;
      sblt_pkg::ST_MEAN_WAIT: begin
        if (!status_i.div_busy) state_d = sblt_pkg::ST_NORM;
      end
      sblt_pkg::ST_NORM: begin
        if (status_i.norm_done) state_d = sblt_pkg::ST_SQ_MUL;
      end
      sblt_pkg::ST_SQ_MUL:    state_d = sblt_pkg::ST_SQ_ADJ;
      sblt_pkg::ST_SQ_ADJ: begin
        state_d = status_i.sq_last ? sblt_pkg::ST_DB_MUL : sblt_pkg::ST_SQ_MUL;
      end
      sblt_pkg::ST_DB_MUL:    state_d = sblt_pkg::ST_DB;
      sblt_pkg::ST_DB:        state_d = sblt_pkg::ST_TILT_MUL;
      sblt_pkg::ST_TILT_MUL:  state_d = sblt_pkg::ST_TILT;
      sblt_pkg::ST_TILT:      state_d = sblt_pkg::ST_TILT_WAIT;
      sblt_pkg::ST_TILT_WAIT: begin
        if (!status_i.div_busy) state_d = sblt_pkg::ST_FLOOR_MUL;
      end
      sblt_pkg::ST_FLOOR_MUL: state_d = sblt_pkg::ST_FLOOR;
      sblt_pkg::ST_FLOOR:     state_d = sblt_pkg::ST_REL;
      sblt_pkg::ST_REL:       state_d = sblt_pkg::ST_TGT_WAIT;
      sblt_pkg::ST_TGT_WAIT: begin
        if (!status_i.div_busy) state_d = sblt_pkg::ST_BAR_MUL;
      end
      sblt_pkg::ST_BAR_MUL:   state_d = sblt_pkg::ST_BAR;
      sblt_pkg::ST_BAR:       state_d = sblt_pkg::ST_ROWS;
      sblt_pkg::ST_ROWS:      state_d = sblt_pkg::ST_EMIT;
      sblt_pkg::ST_EMIT: begin
        if (can_emit) state_d = sblt_pkg::ST_IDLE;
      end
      default:                state_d = sblt_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.accept = accept;
    cmd_o.op     = sblt_pkg::OP_NONE;
    unique case (state_q)
      sblt_pkg::ST_IDLE:      cmd_o.op = sblt_pkg::OP_NONE;
      sblt_pkg::ST_MEAN:      cmd_o.op = sblt_pkg::OP_MEAN_START;
      sblt_pkg::ST_MEAN_WAIT: begin
        if (!status_i.div_busy) cmd_o.op = sblt_pkg::OP_BLEND;
      end
      sblt_pkg::ST_NORM:      cmd_o.op = sblt_pkg::OP_NORM;
      sblt_pkg::ST_SQ_MUL:    cmd_o.op = sblt_pkg::OP_SQ_MUL;
      sblt_pkg::ST_SQ_ADJ:    cmd_o.op = sblt_pkg::OP_SQ_ADJ;
      sblt_pkg::ST_DB_MUL:    cmd_o.op = sblt_pkg::OP_DB_MUL;
      sblt_pkg::ST_DB:        cmd_o.op = sblt_pkg::OP_DB;
      sblt_pkg::ST_TILT_MUL:  cmd_o.op = sblt_pkg::OP_TILT_MUL;
      sblt_pkg::ST_TILT:      cmd_o.op = sblt_pkg::OP_TILT_START;
      sblt_pkg::ST_TILT_WAIT: begin
        if (!status_i.div_busy) cmd_o.op = sblt_pkg::OP_LEVEL;
      end
      sblt_pkg::ST_FLOOR_MUL: cmd_o.op = sblt_pkg::OP_FLOOR_MUL;
      sblt_pkg::ST_FLOOR:     cmd_o.op = sblt_pkg::OP_FLOOR;
      sblt_pkg::ST_REL:       cmd_o.op = sblt_pkg::OP_REL;
      sblt_pkg::ST_TGT_WAIT: begin
        if (!status_i.div_busy) cmd_o.op = sblt_pkg::OP_TGT;
      end
      sblt_pkg::ST_BAR_MUL:   cmd_o.op = sblt_pkg::OP_BAR_MUL;
      sblt_pkg::ST_BAR:       cmd_o.op = sblt_pkg::OP_BAR;
      sblt_pkg::ST_ROWS:      cmd_o.op = sblt_pkg::OP_ROWS;
      sblt_pkg::ST_EMIT: begin
        if (can_emit) cmd_o.op = sblt_pkg::OP_EMIT;
      end
      default:                cmd_o.op = sblt_pkg::OP_NONE;
    endcase
  end

  // output word valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == sblt_pkg::ST_EMIT && can_emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sblt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == sblt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/sblt_dp.sv =====
`timescale 1ns / 1ps
// datapath: band accumulation, log, floor, smoothing, column state memories
module sblt_dp #(
  parameter int COLUMNS       = 32,
  parameter int ROWS          = 8,
  parameter int MAX_BAND_BINS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sblt_pkg::dp_cmd_t     cmd_i,
  output sblt_pkg::dp_status_t  status_o,
  input  logic [23:0]           magnitude_i,
  input  logic [4:0]            column_i,
  input  logic                  relearn_i,
  input  logic                  cfg_we_i,
  input  logic [sblt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sblt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output sblt_pkg::out_word_t   out_o
);

  localparam int CW         = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int NW         = $clog2(MAX_BAND_BINS + 1);
  localparam int RW         = $clog2(ROWS + 1);
  localparam int TILT_DIV   = COLUMNS - 1;
  localparam int TILT_RND   = (COLUMNS - 1) / 2;
  localparam int TILT_SH    = 25;
  localparam int TILT_RECIP = ((1 << TILT_SH) + TILT_DIV - 1) / TILT_DIV;
  localparam int MEMW       = 17 + 17 + 7;

  sblt_pkg::dp_op_e op;
  assign op = cmd_i.op;

  // configuration registers
  logic [16:0] attack_q, decay_q;
  logic [14:0] range_q;
  logic [12:0] tilt_q, margin_q;
  logic [15:0] drop_q;
  logic [6:0]  holdf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q <= sblt_pkg::ATTACK_RST;
      decay_q  <= sblt_pkg::DECAY_RST;
      range_q  <= sblt_pkg::RANGE_RST;
      tilt_q   <= sblt_pkg::TILT_RST;
      margin_q <= sblt_pkg::MARGIN_RST;
      drop_q   <= sblt_pkg::DROP_RST;
      holdf_q  <= sblt_pkg::HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (sblt_pkg::cfg_reg_e'(cfg_index_i))
        sblt_pkg::REG_ATTACK: attack_q <= cfg_data_i;
        sblt_pkg::REG_DECAY:  decay_q  <= cfg_data_i;
        sblt_pkg::REG_RANGE:  range_q  <= cfg_data_i[14:0];
        sblt_pkg::REG_TILT:   tilt_q   <= cfg_data_i[12:0];
        sblt_pkg::REG_MARGIN: margin_q <= cfg_data_i[12:0];
        sblt_pkg::REG_DROP:   drop_q   <= cfg_data_i[15:0];
        sblt_pkg::REG_HOLD:   holdf_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // band accumulation
  logic [23:0] peak_q;
  logic [31:0] sum_q;
  logic [NW-1:0] cnt_q;
  logic [4:0]  col_q;
  logic [32:0] sum_ext;
  logic        col_ok;

  assign col_ok  = int'(column_i) < COLUMNS;
  assign sum_ext = {1'b0, sum_q} + {9'b0, magnitude_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.accept && col_ok && (cnt_q < NW'(MAX_BAND_BINS))) begin
      if (magnitude_i > peak_q) peak_q <= magnitude_i;
      sum_q <= sum_ext[32] ? '1 : sum_ext[31:0];
      cnt_q <= cnt_q + NW'(1);
    end else if (op == sblt_pkg::OP_BLEND) begin
      peak_q <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) col_q <= column_i;
  end

  logic [CW-1:0] idx;
  assign idx = CW'(col_q);

  // per-column seeded marks and valid bits
  logic [COLUMNS-1:0] seeded_q, st_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= '0;
      st_vld_q <= '0;
    end else begin
      if (cmd_i.accept && relearn_i) seeded_q <= '0;
      if (op == sblt_pkg::OP_EMIT) begin
        seeded_q[idx] <= 1'b1;
        st_vld_q[idx] <= 1'b1;
      end
    end
  end

  // registers holding the new column state
  logic [15:0] level_q, fl_q, db_q;
  logic [16:0] tgt_q, bar_q, pk_q;
  logic [6:0]  hold_q;

  // column state memories
  logic [MEMW-1:0] st_mem [COLUMNS];
  logic [15:0]     fl_mem [COLUMNS];
  logic [MEMW-1:0] st_rd_q;
  logic [15:0]     fl_rd_q;
  logic            st_rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (op == sblt_pkg::OP_EMIT) begin
      st_mem[idx] <= {bar_q, pk_q, hold_q};
      fl_mem[idx] <= fl_q;
    end
    if (op == sblt_pkg::OP_MEAN_START) begin
      st_rd_q     <= st_mem[idx];
      fl_rd_q     <= fl_mem[idx];
      st_rd_vld_q <= st_vld_q[idx];
    end
  end

  logic [16:0] cur_bar, cur_pk;
  logic [6:0]  cur_hold;
  assign cur_bar  = st_rd_vld_q ? st_rd_q[40:24] : '0;
  assign cur_pk   = st_rd_vld_q ? st_rd_q[23:7] : '0;
  assign cur_hold = st_rd_vld_q ? st_rd_q[6:0] : '0;

  // shared divider for the mean and the target
  logic        div_start, div_busy;
  logic [31:0] div_dividend, div_quo;
  logic [15:0] div_divisor;
  logic [17:0] rel_c;
  logic        rel_pos;

  assign rel_c   = 18'(level_q) - 18'(fl_q) - 18'(margin_q);
  assign rel_pos = !rel_c[17] && (rel_c != '0);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = sum_q;
    div_divisor  = 16'(cnt_q);
    unique case (op)
      sblt_pkg::OP_MEAN_START: div_start = 1'b1;
      sblt_pkg::OP_REL: begin
        div_start    = rel_pos && (range_q != '0);
        div_dividend = {rel_c[15:0], 16'b0};
        div_divisor  = 16'(range_q);
      end
      default: ;
    endcase
  end

  sblt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // log2 working registers
  logic [27:0] x_q;
  logic [4:0]  e_q;
  logic [31:0] m_q;
  logic [15:0] frac_q;
  logic [3:0]  sq_cnt_q;
  logic [63:0] mul_q;
  logic [27:0] blend_c;
  logic [31:0] sq_c;

  // ten times the blend plus the log bias
  assign blend_c = {1'b0, peak_q, 3'b0} - {4'b0, peak_q}
                 + {3'b0, div_quo[23:0], 1'b0} + {4'b0, div_quo[23:0]}
                 + sblt_pkg::BLEND_BIAS;
  assign sq_c = mul_q[61:30];

  // floor and bar helpers
  logic        lvl_lt;
  logic [17:0] fall_sum;
  logic [15:0] rise_gap;
  logic        up;
  logic [16:0] gap, att, dec, coef;

  assign lvl_lt   = level_q < fl_rd_q;
  assign fall_sum = {2'b0, fl_rd_q} + {1'b0, fl_rd_q, 1'b0} + {1'b0, level_q, 1'b0};
  assign rise_gap = level_q - fl_rd_q;
  assign up       = tgt_q > cur_bar;
  assign gap      = up ? (tgt_q - cur_bar) : (cur_bar - tgt_q);
  assign att      = (attack_q > sblt_pkg::FULL_Q16) ? sblt_pkg::FULL_Q16 : attack_q;
  assign dec      = (decay_q > sblt_pkg::FULL_Q16) ? sblt_pkg::FULL_Q16 : decay_q;
  assign coef     = up ? att : dec;

  // shared multiplier operands
  logic [31:0] mul_a, mul_b;
  logic        mul_en;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (op)
      sblt_pkg::OP_SQ_MUL: begin
        mul_a = m_q;
        mul_b = m_q;
      end
      sblt_pkg::OP_DB_MUL: begin
        mul_a = {11'b0, e_q, frac_q};
        mul_b = sblt_pkg::LOG_TO_DB;
      end
      sblt_pkg::OP_TILT_MUL: begin
        mul_a = 32'(tilt_q);
        mul_b = 32'(col_q);
      end
      // rounded tilt over the column span by reciprocal multiplication
      sblt_pkg::OP_TILT_START: begin
        mul_a = 32'(mul_q[18:0]) + 32'(TILT_RND);
        mul_b = 32'(TILT_RECIP);
      end
      sblt_pkg::OP_FLOOR_MUL: begin
        mul_a = lvl_lt ? 32'(fall_sum) : 32'(rise_gap);
        mul_b = lvl_lt ? sblt_pkg::DIV5_RECIP : sblt_pkg::FLOOR_RISE;
      end
      sblt_pkg::OP_BAR_MUL: begin
        mul_a = 32'(gap);
        mul_b = 32'(coef);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) mul_q <= mul_a * mul_b;
  end

  // arithmetic steps
  logic [40:0] db_sum;
  logic [16:0] db_full, lsum;
  logic [22:0] rise_rnd;
  logic [32:0] bar_rnd;
  logic [16:0] bar_inc;

  assign db_sum   = mul_q[40:0] + 41'(sblt_pkg::DB_RND);
  assign db_full  = db_sum[40:24];
  assign lsum     = {1'b0, db_q} + 17'(mul_q[TILT_SH+12:TILT_SH]);
  assign rise_rnd = mul_q[22:0] + 23'(sblt_pkg::HALF_Q16);
  assign bar_rnd  = mul_q[32:0] + 33'(sblt_pkg::HALF_Q16);
  assign bar_inc  = bar_rnd[32:16];

  always_ff @(posedge clk_i) begin
    unique case (op)
      sblt_pkg::OP_BLEND: begin
        x_q <= blend_c;
        e_q <= sblt_pkg::LOG_TOP_E;
      end
      sblt_pkg::OP_NORM: begin
        if (x_q[27]) begin
          m_q      <= {1'b0, x_q, 3'b0};
          frac_q   <= '0;
          sq_cnt_q <= '0;
        end else begin
          x_q <= {x_q[26:0], 1'b0};
          e_q <= e_q - 5'd1;
        end
      end
      sblt_pkg::OP_SQ_ADJ: begin
        if (sq_c[31]) begin
          m_q    <= {1'b0, sq_c[31:1]};
          frac_q <= {frac_q[14:0], 1'b1};
        end else begin
          m_q    <= sq_c;
          frac_q <= {frac_q[14:0], 1'b0};
        end
        sq_cnt_q <= sq_cnt_q + 4'd1;
      end
      sblt_pkg::OP_DB: begin
        db_q <= (db_full > sblt_pkg::DB_OFFSET) ? 16'(db_full - sblt_pkg::DB_OFFSET) : '0;
      end
      sblt_pkg::OP_LEVEL: begin
        level_q <= (lsum > sblt_pkg::LEVEL_MAX) ? 16'(sblt_pkg::LEVEL_MAX) : lsum[15:0];
      end
      sblt_pkg::OP_FLOOR: begin
        if (!seeded_q[idx]) begin
          fl_q <= level_q;
        end else if (lvl_lt) begin
          fl_q <= mul_q[35:20];
        end else begin
          fl_q <= fl_rd_q + 16'(rise_rnd[22:16]);
        end
      end
      sblt_pkg::OP_TGT: begin
        if (!rel_pos) begin
          tgt_q <= '0;
        end else if (range_q == '0 || div_quo > 32'(sblt_pkg::FULL_Q16)) begin
          tgt_q <= sblt_pkg::FULL_Q16;
        end else begin
          tgt_q <= div_quo[16:0];
        end
      end
      sblt_pkg::OP_BAR: begin
        bar_q <= up ? (cur_bar + bar_inc) : (cur_bar - bar_inc);
        if (tgt_q >= cur_pk) begin
          pk_q   <= tgt_q;
          hold_q <= holdf_q;
        end else if (cur_hold != '0) begin
          pk_q   <= cur_pk;
          hold_q <= cur_hold - 7'd1;
        end else begin
          pk_q   <= (cur_pk > {1'b0, drop_q}) ? (cur_pk - {1'b0, drop_q}) : '0;
          hold_q <= cur_hold;
        end
      end
      default: ;
    endcase
  end

  // display rows
  logic [23:0] bar_x, pk_x, rows_f, prow_f;
  logic [RW-1:0] rows_q, prow_q;

  assign bar_x  = 24'(bar_q) * 24'(ROWS);
  assign pk_x   = 24'(pk_q) * 24'(ROWS);
  assign rows_f = (bar_x + 24'(sblt_pkg::HALF_Q16)) >> 16;
  assign prow_f = (pk_x >= 24'(sblt_pkg::HALF_Q16)) ?
                  ((pk_x - 24'(sblt_pkg::HALF_Q16)) >> 16) : '0;

  always_ff @(posedge clk_i) begin
    if (op == sblt_pkg::OP_ROWS) begin
      rows_q <= (rows_f > 24'(ROWS)) ? RW'(ROWS) : RW'(rows_f);
      prow_q <= (prow_f > 24'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(prow_f);
    end
  end

  // output word register
  sblt_pkg::out_word_t out_q;

  always_ff @(posedge clk_i) begin
    if (op == sblt_pkg::OP_EMIT) begin
      out_q.out_column <= col_q;
      out_q.bar_level  <= bar_q;
      out_q.bar_rows   <= 4'(rows_q);
      out_q.peak_level <= pk_q;
      out_q.peak_row   <= 3'(prow_q);
      out_q.peak_shown <= (pk_q > sblt_pkg::SHOWN_MIN) && (prow_q >= rows_q);
      out_q.level_db   <= level_q;
      out_q.floor_db   <= fl_q;
    end
  end

  assign out_o              = out_q;
  assign status_o.col_ok    = col_ok;
  assign status_o.div_busy  = div_busy;
  assign status_o.norm_done = x_q[27];
  assign status_o.sq_last   = (sq_cnt_q == 4'd15);

endmodule

// ===== hdl/spectrum_bar_level_tracker.sv =====
// bins that do not close a band: accepted one per cycle, no result
// closing bin: the time to the result, plus any output stall, is set by the
// divider (mean, target), the leading-one shift and 16 squarings
// no new bin is taken until that band's result is registered on the output
// reset: registers at defaults, bars, peaks, hold counters and seeded marks cleared
`timescale 1ns / 1ps
`include "spectrum_bar_level_tracker_macros.svh"
module spectrum_bar_level_tracker #(
  parameter int COLUMNS       = 32,
  parameter int ROWS          = 8,
  parameter int MAX_BAND_BINS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sblt_in_if.sink     in_i,
  sblt_out_if.source  out_o,
  sblt_cfg_if.sink    cfg_i
);

  sblt_pkg::dp_cmd_t    cmd;
  sblt_pkg::dp_status_t status;
  sblt_pkg::out_word_t  word;

  assign cfg_i.ready = 1'b1;

  sblt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_of_column),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sblt_dp #(
    .COLUMNS       (COLUMNS),
    .ROWS          (ROWS),
    .MAX_BAND_BINS (MAX_BAND_BINS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .magnitude_i (in_i.magnitude),
    .column_i    (in_i.column),
    .relearn_i   (in_i.relearn),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_o       (word)
  );

  assign out_o.out_column = word.out_column;
  assign out_o.bar_level  = word.bar_level;
  assign out_o.bar_rows   = word.bar_rows;
  assign out_o.peak_level = word.peak_level;
  assign out_o.peak_row   = word.peak_row;
  assign out_o.peak_shown = word.peak_shown;
  assign out_o.level_db   = word.level_db;
  assign out_o.floor_db   = word.floor_db;

  // checks
  `SBLT_ASSERT_NOW(a_div_blocks_in, status.div_busy, !in_i.ready)
  `SBLT_ASSERT_NOW(a_bar_in_range, out_o.valid, out_o.bar_level <= sblt_pkg::FULL_Q16)
  `SBLT_ASSERT_NOW(a_shown_above_min, out_o.valid && out_o.peak_shown, out_o.peak_level > sblt_pkg::SHOWN_MIN)
  `SBLT_ASSERT_NEXT(a_close_starts_band, in_i.valid && in_i.ready && in_i.last_of_column && status.col_ok, !in_i.ready)

endmodule
